FILE: hw/rtl/im2col_pkg.sv
package im2col_pkg;

   // Field widths of the two channels.
   localparam int COL_ROW_W = 18;
   localparam int OUT_POS_W = 10;
   localparam int ADDR_W    = 30;

   // Configuration register widths.
   localparam int DIM_W     = 11;
   localparam int KDIM_W    = 5;
   localparam int STEP_W    = 4;
   localparam int PAD_W     = 4;

   // Configuration port geometry.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_INDEX_W = 3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_IN_HEIGHT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IN_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KER_ROWS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KER_COLS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_ROWS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_COLS = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_H     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_W     = 3'd7;

   // Register reset values.
   localparam logic [DIM_W-1:0]  RST_IN_HEIGHT = 11'd1;
   localparam logic [DIM_W-1:0]  RST_IN_WIDTH  = 11'd1;
   localparam logic [KDIM_W-1:0] RST_KER_ROWS  = 5'd3;
   localparam logic [KDIM_W-1:0] RST_KER_COLS  = 5'd3;
   localparam logic [STEP_W-1:0] RST_STEP_ROWS = 4'd1;
   localparam logic [STEP_W-1:0] RST_STEP_COLS = 4'd1;
   localparam logic [PAD_W-1:0]  RST_PAD_H     = 4'd0;
   localparam logic [PAD_W-1:0]  RST_PAD_W     = 4'd0;

   // Pipelined divider: quotient bits resolved per stage, and stage count.
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = COL_ROW_W / DIV_STEPS;

   // Partial state of a restoring division. The work word shifts dividend
   // bits out at the top and quotient bits in at the bottom.
   typedef struct packed {
      logic [KDIM_W-1:0]    rem;
      logic [COL_ROW_W-1:0] work;
   } div_state_type;

   // Resolves DIV_STEPS quotient bits of a restoring division.
   function automatic div_state_type div_steps(div_state_type s, logic [KDIM_W-1:0] dvs);
      div_state_type r;
      logic [KDIM_W:0] trial;
      r = s;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial  = {r.rem, r.work[COL_ROW_W-1]};
         r.work = {r.work[COL_ROW_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs}) begin
            trial     = trial - {1'b0, dvs};
            r.work[0] = 1'b1;
         end
         r.rem = trial[KDIM_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/im2col_ifs.sv
// Request channel: one column-matrix element position per item.
interface im2col_req_if;
   logic                                valid;
   logic                                ready;
   logic [im2col_pkg::COL_ROW_W-1:0]    col_row;
   logic [im2col_pkg::OUT_POS_W-1:0]    out_y;
   logic [im2col_pkg::OUT_POS_W-1:0]    out_x;

   modport source (output valid, output col_row, output out_y, output out_x, input ready);
   modport sink   (input valid, input col_row, input out_y, input out_x, output ready);
endinterface

// Response channel: one source address or padding flag per item.
interface im2col_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [im2col_pkg::ADDR_W-1:0]       src_address;
   logic                                is_pad;

   modport source (output valid, output src_address, output is_pad, input ready);
   modport sink   (input valid, input src_address, input is_pad, output ready);
endinterface

FILE: hw/rtl/im2col_divider.sv
// Pipelined restoring divider for an 18-bit dividend and a 5-bit divisor.
// Each stage resolves DIV_STEPS quotient bits. Side data travels with the item.
// A stage takes a new item when it is empty or its content moves on.
module im2col_divider #(
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [im2col_pkg::COL_ROW_W-1:0]   in_dividend,
   input  logic [im2col_pkg::KDIM_W-1:0]      in_divisor,
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [im2col_pkg::COL_ROW_W-1:0]   out_quotient,
   output logic [im2col_pkg::KDIM_W-1:0]      out_remainder,
   output logic [SIDE_W-1:0]                  out_side
);

   localparam int LAST = im2col_pkg::DIV_STAGES - 1;

   im2col_pkg::div_state_type          state_ff [im2col_pkg::DIV_STAGES];
   im2col_pkg::div_state_type          state_in [im2col_pkg::DIV_STAGES];
   logic [im2col_pkg::KDIM_W-1:0]      dvs_ff   [im2col_pkg::DIV_STAGES];
   logic [im2col_pkg::KDIM_W-1:0]      dvs_in   [im2col_pkg::DIV_STAGES];
   logic [SIDE_W-1:0]                  side_ff  [im2col_pkg::DIV_STAGES];
   logic [SIDE_W-1:0]                  side_in  [im2col_pkg::DIV_STAGES];
   logic [im2col_pkg::DIV_STAGES-1:0]  v_ff;
   logic [im2col_pkg::DIV_STAGES-1:0]  v_in;
   logic [im2col_pkg::DIV_STAGES-1:0]  en;

   for (genvar s = 0; s < im2col_pkg::DIV_STAGES; s++) begin : g_stage
      // Stage source: the channel input for the first stage, else the prior stage.
      if (s == 0) begin : g_first
         im2col_pkg::div_state_type start;
         always_comb begin
            start.rem  = '0;
            start.work = in_dividend;
            v_in[s]     = in_valid;
            dvs_in[s]   = in_divisor;
            side_in[s]  = in_side;
            state_in[s] = im2col_pkg::div_steps(start, in_divisor);
         end
      end else begin : g_next
         always_comb begin
            v_in[s]     = v_ff[s-1];
            dvs_in[s]   = dvs_ff[s-1];
            side_in[s]  = side_ff[s-1];
            state_in[s] = im2col_pkg::div_steps(state_ff[s-1], dvs_ff[s-1]);
         end
      end

      // A stage may load when it is empty or its item moves on.
      if (s == LAST) begin : g_en_last
         assign en[s] = !v_ff[s] || out_ready;
      end else begin : g_en_mid
         assign en[s] = !v_ff[s] || en[s+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= v_in[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            state_ff[s] <= state_in[s];
            dvs_ff[s]   <= dvs_in[s];
            side_ff[s]  <= side_in[s];
         end
      end
   end

   assign in_ready      = en[0];
   assign out_valid     = v_ff[LAST];
   assign out_quotient  = state_ff[LAST].work;
   assign out_remainder = state_ff[LAST].rem;
   assign out_side      = side_ff[LAST];

endmodule

FILE: hw/rtl/im2col_address_generator_core.sv
// Channel  | Direction | Handshake     | Payload
// req      | in        | valid/ready   | col_row[17:0], out_y[9:0], out_x[9:0]
// rsp      | out       | valid/ready   | src_address[29:0], is_pad
// csr      | in        | APB write/read| 8 registers at byte address 4*i, 32-bit data
//
// One item enters per cycle unless the pipeline is full behind a stall on
// rsp, and it passes through seventeen register stages: two six-stage divider
// pipelines split col_row into kx, ky and channel, then five stages form the
// sample position, the two address products and the output register. Reset is
// synchronous and clears the valid bits and the configuration registers to
// their defaults. Every stage moves on when it is empty or the next stage
// takes its item, so a stall on rsp fills bubbles before req stalls.
module im2col_address_generator_core #(
   parameter int MAX_CHANNELS = 1024,
   parameter int DIL_ROWS     = 1,
   parameter int DIL_COLS     = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   im2col_req_if.sink                           req,
   im2col_rsp_if.source                         rsp,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [im2col_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [im2col_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [im2col_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                 pready
);

   localparam int CHAN_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int POS_MAX_H = (2**im2col_pkg::KDIM_W - 1) * DIL_ROWS
                            + (2**im2col_pkg::OUT_POS_W - 1) * (2**im2col_pkg::STEP_W - 1);
   localparam int POS_MAX_W = (2**im2col_pkg::KDIM_W - 1) * DIL_COLS
                            + (2**im2col_pkg::OUT_POS_W - 1) * (2**im2col_pkg::STEP_W - 1);
   localparam int POS_MAX = (POS_MAX_H > POS_MAX_W) ? POS_MAX_H : POS_MAX_W;
   localparam int POS_W   = $clog2(POS_MAX + 1);
   localparam int PROD_W  = im2col_pkg::DIM_W + CHAN_W;
   localparam int QW      = im2col_pkg::COL_ROW_W + 1;
   localparam int POS2_W  = 2 * im2col_pkg::OUT_POS_W;
   localparam int SIDE2_W = im2col_pkg::KDIM_W + POS2_W;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [im2col_pkg::DIM_W-1:0]      in_height_ff, in_width_ff;
   logic [im2col_pkg::KDIM_W-1:0]     ker_rows_ff, ker_cols_ff;
   logic [im2col_pkg::STEP_W-1:0]     step_rows_ff, step_cols_ff;
   logic [im2col_pkg::PAD_W-1:0]      pad_h_ff, pad_w_ff;
   logic [im2col_pkg::CSR_INDEX_W-1:0] csr_index;
   logic                              csr_write;

   assign csr_index = paddr[im2col_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff <= im2col_pkg::RST_IN_HEIGHT;
         in_width_ff  <= im2col_pkg::RST_IN_WIDTH;
         ker_rows_ff  <= im2col_pkg::RST_KER_ROWS;
         ker_cols_ff  <= im2col_pkg::RST_KER_COLS;
         step_rows_ff <= im2col_pkg::RST_STEP_ROWS;
         step_cols_ff <= im2col_pkg::RST_STEP_COLS;
         pad_h_ff     <= im2col_pkg::RST_PAD_H;
         pad_w_ff     <= im2col_pkg::RST_PAD_W;
      end else if (csr_write) begin
         case (csr_index)
            im2col_pkg::REG_IN_HEIGHT: in_height_ff <= pwdata[im2col_pkg::DIM_W-1:0];
            im2col_pkg::REG_IN_WIDTH:  in_width_ff  <= pwdata[im2col_pkg::DIM_W-1:0];
            im2col_pkg::REG_KER_ROWS:  ker_rows_ff  <= pwdata[im2col_pkg::KDIM_W-1:0];
            im2col_pkg::REG_KER_COLS:  ker_cols_ff  <= pwdata[im2col_pkg::KDIM_W-1:0];
            im2col_pkg::REG_STEP_ROWS: step_rows_ff <= pwdata[im2col_pkg::STEP_W-1:0];
            im2col_pkg::REG_STEP_COLS: step_cols_ff <= pwdata[im2col_pkg::STEP_W-1:0];
            im2col_pkg::REG_PAD_H:     pad_h_ff     <= pwdata[im2col_pkg::PAD_W-1:0];
            im2col_pkg::REG_PAD_W:     pad_w_ff     <= pwdata[im2col_pkg::PAD_W-1:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      case (csr_index)
         im2col_pkg::REG_IN_HEIGHT: prdata = im2col_pkg::CSR_DATA_W'(in_height_ff);
         im2col_pkg::REG_IN_WIDTH:  prdata = im2col_pkg::CSR_DATA_W'(in_width_ff);
         im2col_pkg::REG_KER_ROWS:  prdata = im2col_pkg::CSR_DATA_W'(ker_rows_ff);
         im2col_pkg::REG_KER_COLS:  prdata = im2col_pkg::CSR_DATA_W'(ker_cols_ff);
         im2col_pkg::REG_STEP_ROWS: prdata = im2col_pkg::CSR_DATA_W'(step_rows_ff);
         im2col_pkg::REG_STEP_COLS: prdata = im2col_pkg::CSR_DATA_W'(step_cols_ff);
         im2col_pkg::REG_PAD_H:     prdata = im2col_pkg::CSR_DATA_W'(pad_h_ff);
         im2col_pkg::REG_PAD_W:     prdata = im2col_pkg::CSR_DATA_W'(pad_w_ff);
         default:                   prdata = '0;
      endcase
   end

   // A kernel size of zero counts as one.
   logic [im2col_pkg::KDIM_W-1:0] kw_eff, kh_eff;
   assign kw_eff = (ker_cols_ff == '0) ? im2col_pkg::KDIM_W'(1) : ker_cols_ff;
   assign kh_eff = (ker_rows_ff == '0) ? im2col_pkg::KDIM_W'(1) : ker_rows_ff;

   // ---------------------------------------------------------------------
   // Divider pipelines: kx and t from col_row, then ky and channel from t.
   // ---------------------------------------------------------------------
   logic                                 d1_valid, d1_ready;
   logic [im2col_pkg::COL_ROW_W-1:0]     d1_quot;
   logic [im2col_pkg::KDIM_W-1:0]        d1_rem;
   logic [POS2_W-1:0]                    d1_side;
   logic                                 d2_valid, d2_ready;
   logic [im2col_pkg::COL_ROW_W-1:0]     d2_quot;
   logic [im2col_pkg::KDIM_W-1:0]        d2_rem;
   logic [SIDE2_W-1:0]                   d2_side;

   im2col_divider #(.SIDE_W(POS2_W)) u_div_kw (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req.valid),
      .in_ready      (req.ready),
      .in_dividend   (req.col_row),
      .in_divisor    (kw_eff),
      .in_side       ({req.out_y, req.out_x}),
      .out_valid     (d1_valid),
      .out_ready     (d1_ready),
      .out_quotient  (d1_quot),
      .out_remainder (d1_rem),
      .out_side      (d1_side)
   );

   im2col_divider #(.SIDE_W(SIDE2_W)) u_div_kh (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d1_valid),
      .in_ready      (d1_ready),
      .in_dividend   (d1_quot),
      .in_divisor    (kh_eff),
      .in_side       ({d1_rem, d1_side}),
      .out_valid     (d2_valid),
      .out_ready     (d2_ready),
      .out_quotient  (d2_quot),
      .out_remainder (d2_rem),
      .out_side      (d2_side)
   );

   // ---------------------------------------------------------------------
   // Stage enables: each stage loads when empty or when its item moves on.
   // ---------------------------------------------------------------------
   logic c_v_ff, d_v_ff, e_v_ff, f_v_ff, g_v_ff;
   logic c_en, d_en, e_en, f_en, g_en;

   assign g_en     = !g_v_ff || rsp.ready;
   assign f_en     = !f_v_ff || g_en;
   assign e_en     = !e_v_ff || f_en;
   assign d_en     = !d_v_ff || e_en;
   assign c_en     = !c_v_ff || d_en;
   assign d2_ready = c_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
      end else begin
         if (c_en) begin
            c_v_ff <= d2_valid;
         end
         if (d_en) begin
            d_v_ff <= c_v_ff;
         end
         if (e_en) begin
            e_v_ff <= d_v_ff;
         end
         if (f_en) begin
            f_v_ff <= e_v_ff;
         end
         if (g_en) begin
            g_v_ff <= f_v_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage C: sample row and column, and the bounds checks.
   // ---------------------------------------------------------------------
   logic [im2col_pkg::KDIM_W-1:0]    kx, ky;
   logic [im2col_pkg::OUT_POS_W-1:0] oy, ox;
   logic [POS_W-1:0]                 row_pos, col_pos, row_rel, col_rel;
   logic                             row_ok, col_ok, chan_ok;
   logic [im2col_pkg::DIM_W-1:0]     c_row_ff, c_col_ff;
   logic [CHAN_W-1:0]                c_chan_ff;
   logic                             c_pad_ff;

   assign ky = d2_rem;
   assign {kx, oy, ox} = d2_side;

   always_comb begin
      row_pos = POS_W'(ky) * POS_W'(DIL_ROWS) + POS_W'(oy) * POS_W'(step_rows_ff);
      col_pos = POS_W'(kx) * POS_W'(DIL_COLS) + POS_W'(ox) * POS_W'(step_cols_ff);
      row_rel = row_pos - POS_W'(pad_h_ff);
      col_rel = col_pos - POS_W'(pad_w_ff);
      row_ok  = (row_pos >= POS_W'(pad_h_ff)) && (row_rel < POS_W'(in_height_ff));
      col_ok  = (col_pos >= POS_W'(pad_w_ff)) && (col_rel < POS_W'(in_width_ff));
      chan_ok = QW'(d2_quot) < QW'(MAX_CHANNELS);
   end

   always_ff @(posedge clock) begin
      if (c_en) begin
         c_row_ff  <= row_rel[im2col_pkg::DIM_W-1:0];
         c_col_ff  <= col_rel[im2col_pkg::DIM_W-1:0];
         c_chan_ff <= d2_quot[CHAN_W-1:0];
         c_pad_ff  <= !(row_ok && col_ok && chan_ok);
      end
   end

   // ---------------------------------------------------------------------
   // Stage D: image height times channel.
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0]              d_prod_ff;
   logic [im2col_pkg::DIM_W-1:0]   d_row_ff, d_col_ff;
   logic                           d_pad_ff;

   always_ff @(posedge clock) begin
      if (d_en) begin
         d_prod_ff <= PROD_W'(in_height_ff) * PROD_W'(c_chan_ff);
         d_row_ff  <= c_row_ff;
         d_col_ff  <= c_col_ff;
         d_pad_ff  <= c_pad_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage E: add the row to get the row index within the whole volume.
   // ---------------------------------------------------------------------
   logic [im2col_pkg::ADDR_W-1:0]  e_sum_ff;
   logic [im2col_pkg::DIM_W-1:0]   e_col_ff;
   logic                           e_pad_ff;

   always_ff @(posedge clock) begin
      if (e_en) begin
         e_sum_ff <= im2col_pkg::ADDR_W'(d_prod_ff) + im2col_pkg::ADDR_W'(d_row_ff);
         e_col_ff <= d_col_ff;
         e_pad_ff <= d_pad_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage F: scale by the image width, kept to the address width.
   // ---------------------------------------------------------------------
   logic [im2col_pkg::ADDR_W-1:0]  f_prod_ff;
   logic [im2col_pkg::DIM_W-1:0]   f_col_ff;
   logic                           f_pad_ff;

   always_ff @(posedge clock) begin
      if (f_en) begin
         f_prod_ff <= im2col_pkg::ADDR_W'(in_width_ff) * e_sum_ff;
         f_col_ff  <= e_col_ff;
         f_pad_ff  <= e_pad_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage G: output register; a padding item carries address zero.
   // ---------------------------------------------------------------------
   logic [im2col_pkg::ADDR_W-1:0]  g_addr_ff;
   logic                           g_pad_ff;

   always_ff @(posedge clock) begin
      if (g_en) begin
         g_addr_ff <= f_pad_ff ? '0 : f_prod_ff + im2col_pkg::ADDR_W'(f_col_ff);
         g_pad_ff  <= f_pad_ff;
      end
   end

   assign rsp.valid       = g_v_ff;
   assign rsp.src_address = g_addr_ff;
   assign rsp.is_pad      = g_pad_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // A padding result never carries an address.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_pad |-> rsp.src_address == '0)
      else $error("padding item with nonzero address");

   // The request side stalls only when the output is held by the sink.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid && !rsp.ready)
      else $error("request stalled while output free");

   // An in-bounds item in stage C has a row and a column inside the image.
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      c_v_ff && !c_pad_ff |-> c_row_ff < in_height_ff && c_col_ff < in_width_ff)
      else $error("in-bounds item with position outside image");

   // Reset leaves no result on the output.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result present right after reset");

endmodule
